// File: rtl/artc_pkg.sv
// ----------------------------------------------------------------------------
// artc_pkg: shared types and constants of the ack/retry transmit controller
// Event codes, result codes, frame constants and the front-to-back entry.
// ----------------------------------------------------------------------------
package artc_pkg;

   // event kinds carried in req_tuser
   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_TXDONE = 2'd1;
   localparam logic [1:0] KIND_RXHDR  = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   // result actions
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_DONE = 2'd2;

   // transfer outcomes
   localparam logic [1:0] OUT_OK    = 2'd0;
   localparam logic [1:0] OUT_RADIO = 2'd1;
   localparam logic [1:0] OUT_NOACK = 2'd2;

   // frame header constants
   localparam logic [6:0] ACK_FRAME_LEN  = 7'd5;
   localparam logic [2:0] FRAME_TYPE_ACK = 3'd2;

   // configuration register indexes
   localparam logic CSR_ACK_WAIT    = 1'b0;
   localparam logic CSR_MAX_RETRIES = 1'b1;

   localparam logic [15:0] ACK_WAIT_RESET    = 16'd120;
   localparam logic [2:0]  MAX_RETRIES_RESET = 3'd3;

   // port widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // event queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified event passed from front to back
   // flag: want_ack for a send, radio_ok for tx done, ack-frame match for a header
   // seq:  send_seq for a send, rx_seq for a header
   typedef struct packed {
      logic [1:0] kind;
      logic       flag;
      logic [7:0] seq;
   } event_type;

endpackage

// File: rtl/artc_front.sv
// ----------------------------------------------------------------------------
// artc_front: event classifier
// Unpacks an input beat and reduces it to a compact event for the queue.
// ----------------------------------------------------------------------------
module artc_front (
   input  logic [1:0]                      kind,
   input  logic [artc_pkg::REQ_DATA_W-1:0] data,
   output artc_pkg::event_type             evt
);
   import artc_pkg::*;

   logic       want_ack;
   logic [7:0] send_seq;
   logic       radio_ok;
   logic [6:0] rx_length;
   logic [7:0] rx_control_low;
   logic [7:0] rx_seq;
   logic       is_ack_frame;

   // field unpacking
   assign want_ack       = data[0];
   assign send_seq       = data[8:1];
   assign radio_ok       = data[9];
   assign rx_length      = data[16:10];
   assign rx_control_low = data[24:17];
   assign rx_seq         = data[32:25];

   // header is an ack frame of the right length
   assign is_ack_frame = (rx_length == ACK_FRAME_LEN) &&
                         (rx_control_low[2:0] == FRAME_TYPE_ACK);

   // event reduction
   always_comb begin
      evt.kind = kind;
      evt.flag = 1'b0;
      evt.seq  = 8'd0;
      unique case (kind)
         KIND_SEND: begin
            evt.flag = want_ack;
            evt.seq  = send_seq;
         end
         KIND_TXDONE: begin
            evt.flag = radio_ok;
         end
         KIND_RXHDR: begin
            evt.flag = is_ack_frame;
            evt.seq  = rx_seq;
         end
         default: begin
            evt.flag = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/artc_queue.sv
// ----------------------------------------------------------------------------
// artc_queue: short event queue
// Small register fifo between the classifier and the transfer engine.
// ----------------------------------------------------------------------------
module artc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  artc_pkg::event_type push_evt,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output artc_pkg::event_type head_evt
);
   import artc_pkg::*;

   event_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_evt  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

endmodule

// File: rtl/artc_back.sv
// ----------------------------------------------------------------------------
// artc_back: transfer engine
// Holds the transfer state and registers, executes one event per cycle unless
// the result beat stalls, and keeps the result beat in an output register.
// ----------------------------------------------------------------------------
module artc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [15:0]         csr_wdata,
   input  logic                evt_valid,
   input  artc_pkg::event_type evt,
   output logic                evt_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_action,
   output logic [1:0]          rsp_outcome,
   output logic                rsp_busy,
   output logic                rsp_awaiting
);
   import artc_pkg::*;

   logic [15:0] ack_wait_ff;
   logic [2:0]  max_retries_ff;

   logic        tx_busy_ff, tx_busy_in;
   logic        ack_pending_ff, ack_pending_in;
   logic        timer_run_ff, timer_run_in;
   logic [2:0]  retries_ff, retries_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  frame_seq_ff, frame_seq_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  action_ff;
   logic [1:0]  outcome_ff;
   logic        busy_ff;
   logic        awaiting_ff;

   logic [1:0]  act;
   logic [1:0]  res;
   logic [16:0] tick_next;
   logic        retry_req;
   logic [1:0]  fail_code;
   logic        finish_req;
   logic [1:0]  finish_code;

   // take an event when the result register is free or being drained
   assign evt_pop   = evt_valid && (!rsp_valid_ff || rsp_tready);
   assign tick_next = {1'b0, elapsed_ff} + 17'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_wait_ff    <= ACK_WAIT_RESET;
         max_retries_ff <= MAX_RETRIES_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ACK_WAIT:    ack_wait_ff    <= csr_wdata;
            CSR_MAX_RETRIES: max_retries_ff <= csr_wdata[2:0];
            default:         ack_wait_ff    <= ack_wait_ff;
         endcase
      end
   end

   // event decode
   always_comb begin
      retry_req   = 1'b0;
      fail_code   = OUT_OK;
      finish_req  = 1'b0;
      finish_code = OUT_OK;
      tx_busy_in     = tx_busy_ff;
      ack_pending_in = ack_pending_ff;
      timer_run_in   = timer_run_ff;
      retries_in     = retries_ff;
      elapsed_in     = elapsed_ff;
      frame_seq_in   = frame_seq_ff;
      act = ACT_NONE;
      res = OUT_OK;

      unique case (evt.kind)
         KIND_SEND: begin
            if (!tx_busy_ff) begin
               tx_busy_in     = 1'b1;
               ack_pending_in = evt.flag;
               timer_run_in   = 1'b0;
               elapsed_in     = '0;
               retries_in     = max_retries_ff;
               frame_seq_in   = evt.seq;
               act            = ACT_SEND;
            end
         end
         KIND_TXDONE: begin
            if (tx_busy_ff && !timer_run_ff) begin
               if (!evt.flag) begin
                  retry_req = 1'b1;
                  fail_code = OUT_RADIO;
               end else if (!ack_pending_ff) begin
                  finish_req  = 1'b1;
                  finish_code = OUT_OK;
               end else begin
                  timer_run_in = 1'b1;
                  elapsed_in   = '0;
               end
            end
         end
         KIND_RXHDR: begin
            if (evt.flag && (evt.seq == frame_seq_ff) && tx_busy_ff && ack_pending_ff) begin
               ack_pending_in = 1'b0;
               if (timer_run_ff) begin
                  finish_req  = 1'b1;
                  finish_code = OUT_OK;
               end
            end
         end
         default: begin
            if (tx_busy_ff && timer_run_ff && ack_pending_ff) begin
               if (tick_next > {1'b0, ack_wait_ff}) begin
                  retry_req = 1'b1;
                  fail_code = OUT_NOACK;
               end else begin
                  elapsed_in = tick_next[15:0];
               end
            end
         end
      endcase

      // retransmit while retries remain, else end the transfer
      if (retry_req) begin
         if (retries_ff != 3'd0) begin
            retries_in   = retries_ff - 3'd1;
            timer_run_in = 1'b0;
            elapsed_in   = '0;
            act          = ACT_SEND;
         end else begin
            finish_req  = 1'b1;
            finish_code = fail_code;
         end
      end

      if (finish_req) begin
         tx_busy_in     = 1'b0;
         ack_pending_in = 1'b0;
         timer_run_in   = 1'b0;
         elapsed_in     = '0;
         act            = ACT_DONE;
         res            = finish_code;
      end
   end

   // transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_busy_ff     <= 1'b0;
         ack_pending_ff <= 1'b0;
         timer_run_ff   <= 1'b0;
         retries_ff     <= '0;
         elapsed_ff     <= '0;
         frame_seq_ff   <= '0;
      end else if (evt_pop) begin
         tx_busy_ff     <= tx_busy_in;
         ack_pending_ff <= ack_pending_in;
         timer_run_ff   <= timer_run_in;
         retries_ff     <= retries_in;
         elapsed_ff     <= elapsed_in;
         frame_seq_ff   <= frame_seq_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (evt_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         action_ff   <= act;
         outcome_ff  <= res;
         busy_ff     <= tx_busy_in;
         awaiting_ff <= ack_pending_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_action   = action_ff;
   assign rsp_outcome  = outcome_ff;
   assign rsp_busy     = busy_ff;
   assign rsp_awaiting = awaiting_ff;

endmodule

// File: rtl/ack_retry_tx_controller.sv
// ----------------------------------------------------------------------------
// ack_retry_tx_controller: transmit acknowledgement and retry controller
// Tracks one transfer of an 802.15.4-style MAC: transmit orders, ack wait
// timing, retransmissions and the final outcome.
//
//   channel | direction | contents
//   req_    | in        | event beats: kind on tuser, event fields on tdata
//   rsp_    | out       | one result beat per event: action on tuser
//   csr_    | in        | register writes: 0 ack_wait_ticks, 1 max_retries
//
// Every event yields one result beat, at one event per cycle sustained while
// the result side accepts; a beat passes the queue, then the result register,
// and the rate is limited by the single state update of the engine.
// Reset is synchronous and clears all control state and the registers to
// their defaults. A stalled result side fills the two-entry event queue,
// after which req_tready drops; input and output stall independently.
// ----------------------------------------------------------------------------
module ack_retry_tx_controller (
   input  logic                            clock,
   input  logic                            reset,
   // input events
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // kind
   input  logic [1:0]                      req_tuser,
   // want_ack, send_seq[7:0], radio_ok, rx_length[6:0], rx_control_low[7:0],
   // rx_seq[7:0], zero fill
   input  logic [artc_pkg::REQ_DATA_W-1:0] req_tdata,
   // results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // action
   output logic [1:0]                      rsp_tuser,
   // outcome[1:0], busy_res, awaiting_ack, zero fill
   output logic [artc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [15:0]                     csr_wdata
);
   import artc_pkg::*;

   event_type  front_evt;
   event_type  head_evt;
   logic       q_full;
   logic       q_not_empty;
   logic       q_pop;
   logic [1:0] outcome;
   logic       busy;
   logic       awaiting;

   assign req_tready = !q_full;

   // classify the incoming beat
   artc_front u_front (
      .kind (req_tuser),
      .data (req_tdata),
      .evt  (front_evt)
   );

   // decouple classifier and engine
   artc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_evt  (front_evt),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_evt  (head_evt)
   );

   // execute events
   artc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .evt_valid    (q_not_empty),
      .evt          (head_evt),
      .evt_pop      (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_action   (rsp_tuser),
      .rsp_outcome  (outcome),
      .rsp_busy     (busy),
      .rsp_awaiting (awaiting)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 4){1'b0}}, awaiting, busy, outcome};

endmodule

// File: tb/sv/tb_ack_retry_tx_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_retry_tx_controller: self-checking bench of the ack/retry controller
// Walks a table of directed events, then random transfer sequences under
// several register settings, extremes included. Every result beat is
// compared field by field with a typed row or a cycle-free controller model.
// ----------------------------------------------------------------------------
module tb_ack_retry_tx_controller;
   import artc_pkg::*;

   // one input event, unpacked from req_tuser / req_tdata
   typedef struct packed {
      logic [1:0] kind;
      logic       want_ack;
      logic [7:0] send_seq;
      logic       radio_ok;
      logic [6:0] rx_len;
      logic [7:0] rx_ctl;
      logic [7:0] rx_seq;
   } tx_event_t;

   // one result beat
   typedef struct packed {
      logic [1:0] action;
      logic [1:0] outcome;
      logic       busy;
      logic       awaiting;
   } result_t;

   // directed stimulus row: a register write or an event, with an optional
   // hand-written expectation
   typedef struct packed {
      logic        is_csr;
      logic        csr_idx;
      logic [15:0] csr_val;
      logic [1:0]  kind;
      logic        want_ack;
      logic [7:0]  send_seq;
      logic        radio_ok;
      logic [6:0]  rx_len;
      logic [7:0]  rx_ctl;
      logic [7:0]  rx_seq;
      logic        typed;
      logic [1:0]  x_action;
      logic [1:0]  x_outcome;
      logic        x_busy;
      logic        x_ack;
   } dir_row_t;

   localparam int DIR_N = 28;
   // csr, idx, value, kind, want_ack, send_seq, radio_ok, rx_len, rx_ctl, rx_seq,
   // typed, action, outcome, busy, awaiting
   localparam dir_row_t DIRECTED [DIR_N] = '{
      // idle: tick, transmit done and a matching ack are all ignored
      '{0, 0, 0, KIND_TICK,   0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 1, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 1, 7'd0,   8'h00, 8'h00, 1, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd5,   8'h02, 8'h00, 1, ACT_NONE, OUT_OK, 0, 0},
      // no-ack frame, send while busy, good transmit ends it
      '{0, 0, 0, KIND_SEND,   0, 8'hFF, 0, 7'd0,   8'h00, 8'h00, 1, ACT_SEND, OUT_OK, 1, 0},
      '{0, 0, 0, KIND_SEND,   1, 8'h00, 0, 7'd0,   8'h00, 8'h00, 1, ACT_NONE, OUT_OK, 1, 0},
      '{0, 0, 0, KIND_TXDONE, 1, 8'hFF, 1, 7'd127, 8'hFF, 8'hFF, 1, ACT_DONE, OUT_OK, 0, 0},
      '{1, CSR_ACK_WAIT,    16'd1, KIND_SEND, 0, 8'h00, 0, 7'd0, 8'h00, 8'h00,
        0, ACT_NONE, OUT_OK, 0, 0},
      '{1, CSR_MAX_RETRIES, 16'd1, KIND_SEND, 0, 8'h00, 0, 7'd0, 8'h00, 8'h00,
        0, ACT_NONE, OUT_OK, 0, 0},
      // radio failures use up the retries
      '{0, 0, 0, KIND_SEND,   1, 8'h00, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 1, ACT_DONE, OUT_RADIO, 0, 0},
      // ack arrives before the transmit done
      '{0, 0, 0, KIND_SEND,   1, 8'hA5, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd5,   8'hFA, 8'hA5, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 1, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      // ack wait: stray transmit done, bad length, bad type, bad sequence
      '{0, 0, 0, KIND_SEND,   1, 8'h5A, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 1, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd127, 8'h02, 8'h5A, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd5,   8'hFB, 8'h5A, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd5,   8'h02, 8'h5B, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TICK,   0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      // wait lowered below the running count: next tick times out
      '{1, CSR_ACK_WAIT,    16'd0, KIND_SEND, 0, 8'h00, 0, 7'd0, 8'h00, 8'h00,
        0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TICK,   0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 1, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TICK,   0, 8'h00, 0, 7'd0,   8'h00, 8'h00, 1, ACT_DONE, OUT_NOACK, 0, 0},
      // matching ack during the wait
      '{0, 0, 0, KIND_SEND,   1, 8'h33, 0, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_TXDONE, 0, 8'h00, 1, 7'd0,   8'h00, 8'h00, 0, ACT_NONE, OUT_OK, 0, 0},
      '{0, 0, 0, KIND_RXHDR,  0, 8'h00, 0, 7'd5,   8'h02, 8'h33, 1, ACT_DONE, OUT_OK, 0, 0}
   };

   // random phases: register settings, extremes included
   localparam int N_PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 270;
   localparam int PRESSURE_PHASE  = 1;
   localparam int HOLD_CYCLES     = 400;
   localparam logic [15:0] PHASE_WAIT [N_PHASES] =
      '{16'd0, 16'd2, 16'd65535, 16'd5, 16'd1, 16'd120};
   localparam logic [2:0] PHASE_RETRIES [N_PHASES] =
      '{3'd0, 3'd7, 3'd7, 3'd1, 3'd3, 3'd2};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_addr   = 1'b0;
   logic [15:0]           csr_wdata  = '0;

   ack_retry_tx_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // controller model state and registers
   logic        st_busy     = 1'b0;
   logic        st_ack      = 1'b0;
   logic        st_timer    = 1'b0;
   logic [2:0]  st_retries  = '0;
   logic [15:0] st_elapsed  = '0;
   logic [7:0]  st_seq      = '0;
   logic [15:0] cfg_wait    = ACK_WAIT_RESET;
   logic [2:0]  cfg_retries = MAX_RETRIES_RESET;

   result_t pending_results [$];
   int      fail_count     = 0;
   int      events_sent    = 0;
   int      results_seen   = 0;
   int      transmit_count = 0;
   int      outcome_count [3] = '{0, 0, 0};

   // sender pacing
   int   burst_left = 0;

   // receiver pacing
   int   hold_requests = 0;
   int   hold_served   = 0;
   int   hold_left     = 0;
   int   stretch_left  = 0;
   int   stall_mode    = 0;
   logic [1:0] rx_phase = '0;
   logic ready_next;
   result_t got, want;

   function automatic void close_transfer(inout result_t r, input logic [1:0] code);
      st_busy    = 1'b0;
      st_ack     = 1'b0;
      st_timer   = 1'b0;
      st_elapsed = '0;
      r.action   = ACT_DONE;
      r.outcome  = code;
   endfunction

   function automatic void retry_or_close(inout result_t r, input logic [1:0] code);
      if (st_retries != 0) begin
         st_retries = st_retries - 3'd1;
         st_timer   = 1'b0;
         st_elapsed = '0;
         r.action   = ACT_SEND;
      end else begin
         close_transfer(r, code);
      end
   endfunction

   // advance the controller model by one event and return its result
   function automatic result_t predict_tx_step(input tx_event_t ev);
      result_t     r;
      logic [16:0] next_count;
      r = '0;
      r.action  = ACT_NONE;
      r.outcome = OUT_OK;
      case (ev.kind)
         KIND_SEND: begin
            if (!st_busy) begin
               st_busy    = 1'b1;
               st_ack     = ev.want_ack;
               st_timer   = 1'b0;
               st_elapsed = '0;
               st_retries = cfg_retries;
               st_seq     = ev.send_seq;
               r.action   = ACT_SEND;
            end
         end
         KIND_TXDONE: begin
            if (st_busy && !st_timer) begin
               if (!ev.radio_ok) begin
                  retry_or_close(r, OUT_RADIO);
               end else if (!st_ack) begin
                  close_transfer(r, OUT_OK);
               end else begin
                  st_timer   = 1'b1;
                  st_elapsed = '0;
               end
            end
         end
         KIND_RXHDR: begin
            if (ev.rx_len == ACK_FRAME_LEN && ev.rx_ctl[2:0] == FRAME_TYPE_ACK &&
                ev.rx_seq == st_seq && st_busy && st_ack) begin
               st_ack = 1'b0;
               if (st_timer) close_transfer(r, OUT_OK);
            end
         end
         default: begin
            if (st_busy && st_timer && st_ack) begin
               next_count = {1'b0, st_elapsed} + 17'd1;
               if (next_count > {1'b0, cfg_wait}) retry_or_close(r, OUT_NOACK);
               else st_elapsed = next_count[15:0];
            end
         end
      endcase
      r.busy     = st_busy;
      r.awaiting = st_ack;
      return r;
   endfunction

   // random event shaped by the model state: mostly well-formed transfers
   function automatic tx_event_t random_event();
      tx_event_t   ev;
      int unsigned roll;
      ev.kind     = 2'($urandom_range(3));
      ev.want_ack = 1'($urandom_range(1));
      ev.send_seq = 8'($urandom_range(255));
      ev.radio_ok = 1'($urandom_range(1));
      ev.rx_len   = 7'($urandom_range(127));
      ev.rx_ctl   = 8'($urandom_range(255));
      ev.rx_seq   = 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 12) return ev;
      if (!st_busy) begin
         ev.kind = KIND_SEND;
         ev.want_ack = ($urandom_range(99) < 75);
      end else if (!st_timer) begin
         if (roll < 20) ev.kind = KIND_RXHDR;
         else if (roll < 24) ev.kind = KIND_SEND;
         else begin
            ev.kind     = KIND_TXDONE;
            ev.radio_ok = ($urandom_range(99) < 65);
         end
      end else begin
         ev.kind = (roll < 27) ? KIND_RXHDR : KIND_TICK;
      end
      // ack frame, now and then broken in one header field
      if (ev.kind == KIND_RXHDR) begin
         ev.rx_len      = ACK_FRAME_LEN;
         ev.rx_ctl[2:0] = FRAME_TYPE_ACK;
         ev.rx_seq      = st_seq;
         case ($urandom_range(7))
            0: ev.rx_len      = 7'($urandom_range(127));
            1: ev.rx_ctl[2:0] = 3'($urandom_range(7));
            2: ev.rx_seq      = 8'($urandom_range(255));
            default: ;
         endcase
      end
      return ev;
   endfunction

   // offer one event beat, record its expectation on acceptance, then pace
   task automatic send_event(input tx_event_t ev, input logic typed,
                             input result_t typed_result);
      result_t r;
      req_tvalid <= 1'b1;
      req_tuser  <= ev.kind;
      req_tdata  <= {7'd0, ev.rx_seq, ev.rx_ctl, ev.rx_len, ev.radio_ok,
                     ev.send_seq, ev.want_ack};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_tx_step(ev);
      pending_results.push_back(typed ? typed_result : r);
      events_sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // let every outstanding result come back, then wait out a margin
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_ACK_WAIT) cfg_wait = value;
      else cfg_retries = value[2:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // result side: check accepted beats and pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[3]};
         results_seen++;
         if (got.action == ACT_SEND) transmit_count++;
         if (got.action == ACT_DONE && got.outcome <= OUT_NOACK)
            outcome_count[got.outcome]++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: action %0d", got.action);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, got.action);
               fail_count++;
            end
            if (got.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
               fail_count++;
            end
            if (got.busy !== want.busy) begin
               $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
               fail_count++;
            end
            if (got.awaiting !== want.awaiting) begin
               $error("awaiting_ack: expected %0d, got %0d", want.awaiting, got.awaiting);
               fail_count++;
            end
         end
      end
      rx_phase = rx_phase + 2'd1;
      if (hold_left != 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left  = HOLD_CYCLES;
         ready_next = 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stall_mode   = $urandom_range(2);
            stretch_left = $urandom_range(20, 200);
         end else begin
            stretch_left--;
         end
         case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = 1'($urandom_range(1));
            default: ready_next = (rx_phase == 2'd0);
         endcase
      end
      rsp_tready <= ready_next;
   end

   // stimulus
   initial begin
      dir_row_t  row;
      tx_event_t ev;
      result_t   no_result;
      no_result = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.is_csr) begin
            drain_results();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            ev.kind     = row.kind;
            ev.want_ack = row.want_ack;
            ev.send_seq = row.send_seq;
            ev.radio_ok = row.radio_ok;
            ev.rx_len   = row.rx_len;
            ev.rx_ctl   = row.rx_ctl;
            ev.rx_seq   = row.rx_seq;
            send_event(ev, row.typed,
                       {row.x_action, row.x_outcome, row.x_busy, row.x_ack});
         end
      end

      // random transfers under each register setting
      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         write_csr(CSR_ACK_WAIT, PHASE_WAIT[p]);
         write_csr(CSR_MAX_RETRIES, {13'd0, PHASE_RETRIES[p]});
         if (p == PRESSURE_PHASE) hold_requests++;
         repeat (ITEMS_PER_PHASE) send_event(random_event(), 1'b0, no_result);
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("run covered %0d events and %0d result beats, %0d transmit orders",
               events_sent, results_seen, transmit_count);
      $display("finished transfers: %0d ok, %0d radio error, %0d no ack",
               outcome_count[OUT_OK], outcome_count[OUT_RADIO], outcome_count[OUT_NOACK]);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
